// ===== hw/rtl/mp5lf_pkg.sv =====
// mp5lf_pkg: shared types, constants and limiter helper functions for the
// MP5 left face reconstruction pipeline. No dependencies.
package mp5lf_pkg;

  // Internal values are integers in units of one sample LSB / 60
  localparam int VW = 44;
  typedef logic signed [VW-1:0] val_t;

  // Magnitudes of the two deviation terms and their product
  localparam int MW = 40;
  localparam int HW = MW / 2;
  localparam int PW = 2 * MW;
  typedef logic [MW-1:0] mag_t;
  typedef logic [HW-1:0] half_t;
  typedef logic [2*HW-1:0] pp_t;
  typedef logic [PW-1:0] prod_t;

  // Trigger level scaled by 60 * 60 so it compares against the raw product
  localparam int LW = 44;
  typedef logic [LW-1:0] lim_t;
  localparam logic [11:0] TRIG_SCALE = 12'd3600;

  // Rounding divide by 60 with saturation to 32 bits
  localparam val_t ROUND_BIAS = val_t'(30);
  localparam val_t SAT_SPAN   = val_t'(60 * (64'sd1 <<< 31));
  localparam int QW  = 36;           // width of (n + span) / 4
  localparam int MLW = 20;           // low part of the split quotient
  localparam int MHW = QW - MLW;
  localparam int SW  = MLW + 1;      // low part plus high part
  localparam int P1W = 33;
  localparam int P2W = 43;
  localparam int RSH = 25;
  localparam logic [16:0] HI_STEP = 17'd69905;    // (2^20 - 1) / 15
  localparam logic [21:0] RECIP15 = 22'd2236963;  // ceil(2^25 / 15)
  localparam logic [31:0] FACE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] FACE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
  } r60_en_t;

  function automatic val_t sx32(logic signed [31:0] v);
    return val_t'(v);
  endfunction

  // minmod of two: smaller magnitude when signs agree, else zero
  function automatic val_t mm2(val_t a, val_t b);
    val_t r;
    r = '0;
    if (a > 0 && b > 0) begin
      r = (a < b) ? a : b;
    end else if (a < 0 && b < 0) begin
      r = (a > b) ? a : b;
    end
    return r;
  endfunction

  function automatic val_t mm4(val_t a, val_t b, val_t c, val_t d);
    val_t lo_ab;
    val_t lo_cd;
    val_t hi_ab;
    val_t hi_cd;
    val_t r;
    lo_ab = (a < b) ? a : b;
    lo_cd = (c < d) ? c : d;
    hi_ab = (a > b) ? a : b;
    hi_cd = (c > d) ? c : d;
    r = '0;
    if (a > 0 && b > 0 && c > 0 && d > 0) begin
      r = (lo_ab < lo_cd) ? lo_ab : lo_cd;
    end else if (a < 0 && b < 0 && c < 0 && d < 0) begin
      r = (hi_ab > hi_cd) ? hi_ab : hi_cd;
    end
    return r;
  endfunction

  function automatic val_t min3(val_t a, val_t b, val_t c);
    val_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic val_t max3(val_t a, val_t b, val_t c);
    val_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage

// ===== hw/rtl/mp5lf_round60.sv =====
// mp5lf_round60: three-stage divide by 60 (round to nearest, ties up) with
// saturation to signed 32 bits. Uses mp5lf_pkg. Stage loads come from the top.
module mp5lf_round60 (
  input  logic                  clk,
  input  mp5lf_pkg::r60_en_t    en,
  input  mp5lf_pkg::val_t       ql_i,
  input  logic                  lim_i,
  output logic [31:0]           face_o,
  output logic                  lim_o
);

  localparam int RSH_W = mp5lf_pkg::RSH;

  // stage A: bias, range check, split of (n + span) / 4
  logic                       a_sat_hi_r, a_sat_lo_r, a_lim_r;
  logic [mp5lf_pkg::MHW-1:0]  a_mh_r;
  logic [mp5lf_pkg::SW-1:0]   a_s_r;
  // stage B: the two partial quotients
  logic                       b_sat_hi_r, b_sat_lo_r, b_lim_r;
  logic [mp5lf_pkg::P1W-1:0]  b_p1_r;
  logic [mp5lf_pkg::P2W-RSH_W-1:0] b_p2_r;
  // stage C: result
  logic [31:0]                c_face_r;
  logic                       c_lim_r;

  mp5lf_pkg::val_t            n_a, np_a;
  logic [mp5lf_pkg::QW-1:0]   m_a;
  logic [mp5lf_pkg::SW-1:0]   s_a_nxt;
  logic [mp5lf_pkg::P1W-1:0]  p1_b_nxt;
  logic [mp5lf_pkg::P2W-1:0]  p2_b;
  logic [mp5lf_pkg::P1W-1:0]  q_c;
  logic [31:0]                face_c_nxt;

  always_comb begin
    n_a  = ql_i + mp5lf_pkg::ROUND_BIAS;
    np_a = n_a + mp5lf_pkg::SAT_SPAN;
    m_a  = np_a[mp5lf_pkg::QW+1:2];
    // 2^20 = 15 * HI_STEP + 1, so m / 15 = mh * HI_STEP + (mh + ml) / 15
    s_a_nxt = mp5lf_pkg::SW'(m_a[mp5lf_pkg::QW-1:mp5lf_pkg::MLW])
            + mp5lf_pkg::SW'(m_a[mp5lf_pkg::MLW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en.ld_a) begin
      a_sat_hi_r <= (n_a >= mp5lf_pkg::SAT_SPAN);
      a_sat_lo_r <= (n_a < -mp5lf_pkg::SAT_SPAN);
      a_lim_r    <= lim_i;
      a_mh_r     <= m_a[mp5lf_pkg::QW-1:mp5lf_pkg::MLW];
      a_s_r      <= s_a_nxt;
    end
  end

  always_comb begin
    p1_b_nxt = mp5lf_pkg::P1W'(a_mh_r) * mp5lf_pkg::P1W'(mp5lf_pkg::HI_STEP);
    p2_b     = mp5lf_pkg::P2W'(a_s_r) * mp5lf_pkg::P2W'(mp5lf_pkg::RECIP15);
  end

  always_ff @(posedge clk) begin
    if (en.ld_b) begin
      b_sat_hi_r <= a_sat_hi_r;
      b_sat_lo_r <= a_sat_lo_r;
      b_lim_r    <= a_lim_r;
      b_p1_r     <= p1_b_nxt;
      b_p2_r     <= p2_b[mp5lf_pkg::P2W-1:RSH_W];
    end
  end

  always_comb begin
    q_c = b_p1_r + mp5lf_pkg::P1W'(b_p2_r);
    // quotient is offset by 2^31: flip the top bit to get two's complement
    if (b_sat_hi_r) begin
      face_c_nxt = mp5lf_pkg::FACE_MAX;
    end else if (b_sat_lo_r) begin
      face_c_nxt = mp5lf_pkg::FACE_MIN;
    end else begin
      face_c_nxt = {~q_c[31], q_c[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_c) begin
      c_face_r <= face_c_nxt;
      c_lim_r  <= b_lim_r;
    end
  end

  assign face_o = c_face_r;
  assign lim_o  = c_lim_r;

endmodule

// ===== hw/rtl/mp5_left_face_reconstruction_top.sv =====
// mp5_left_face_reconstruction_top: MP5 (alpha = 2) left face value from a
// five-cell stencil. Uses mp5lf_pkg and mp5lf_round60.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: five signed 32-bit cells
//  out_    | out | out_tvalid/out_tready| out_tdata: face_value, out_tuser: limited
//  cfg_    | in  | cfg_wen              | cfg_wdata: trigger_threshold
//
// One item per cycle sustained while the output is not stalled; an item passes
// through the ten register stages (stencil sums, minmod terms, bounds,
// magnitudes, four 20x20 partial products, product sum, trigger, three for
// the divide by 60) in that order.
// Reset clears the stage valid bits and the threshold. A stalled output holds;
// empty stages behind it keep filling, so input is refused only when every
// stage holds an item.
module mp5_left_face_reconstruction_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] cell_far_left, [63:32] cell_left, [95:64] cell_centre,
  // [127:96] cell_right, [159:128] cell_far_right
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] face_value
  output logic [31:0]  out_tdata,
  // [0] limited
  output logic         out_tuser,
  input  logic         cfg_wen,
  input  logic [31:0]  cfg_wdata
);

  localparam int NS = 10;

  logic [NS-1:0]       v_r;
  logic [NS-1:0]       en;
  mp5lf_pkg::lim_t     thr_lim_r;

  // ---------------- stage control ----------------
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_lim_r <= '0;
    end else if (cfg_wen) begin
      thr_lim_r <= mp5lf_pkg::LW'(cfg_wdata) * mp5lf_pkg::LW'(mp5lf_pkg::TRIG_SCALE);
    end
  end

  assign in_tready = en[0];

  // ---------------- stage 0: linear sums ----------------
  mp5lf_pkg::val_t a_i, b_i, c_i, d_i, e_i;
  mp5lf_pkg::val_t s0_ql_r, s0_c_r, s0_c60_r, s0_d60_r, s0_ul_r, s0_cb30_r, s0_cd_r;
  mp5lf_pkg::val_t s0_dmc_r, s0_dcb2_r, s0_dm_r, s0_dc_r, s0_dp_r;

  always_comb begin
    a_i = mp5lf_pkg::sx32(in_tdata[31:0]);
    b_i = mp5lf_pkg::sx32(in_tdata[63:32]);
    c_i = mp5lf_pkg::sx32(in_tdata[95:64]);
    d_i = mp5lf_pkg::sx32(in_tdata[127:96]);
    e_i = mp5lf_pkg::sx32(in_tdata[159:128]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_ql_r   <= 2 * a_i - 13 * b_i + 47 * c_i + 27 * d_i - 3 * e_i;
      s0_c_r    <= c_i;
      s0_c60_r  <= 60 * c_i;
      s0_d60_r  <= 60 * d_i;
      s0_ul_r   <= 60 * (3 * c_i - 2 * b_i);
      s0_cb30_r <= 30 * (c_i - b_i);
      s0_cd_r   <= c_i + d_i;
      s0_dmc_r  <= d_i - c_i;
      s0_dcb2_r <= 2 * (c_i - b_i);
      s0_dm_r   <= a_i + c_i - 2 * b_i;
      s0_dc_r   <= b_i + d_i - 2 * c_i;
      s0_dp_r   <= c_i + e_i - 2 * d_i;
    end
  end

  // ---------------- stage 1: minmod terms ----------------
  mp5lf_pkg::val_t s1_ql_r, s1_mp_r, s1_x_r, s1_cm_r, s1_cp_r;
  mp5lf_pkg::val_t s1_c60_r, s1_d60_r, s1_ul_r, s1_cb30_r, s1_cd_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ql_r   <= s0_ql_r;
      s1_mp_r   <= s0_c_r + mp5lf_pkg::mm2(s0_dmc_r, s0_dcb2_r);
      s1_x_r    <= s0_ql_r - s0_c60_r;
      s1_cm_r   <= mp5lf_pkg::mm4(4 * s0_dm_r - s0_dc_r, 4 * s0_dc_r - s0_dm_r,
                                  s0_dm_r, s0_dc_r);
      s1_cp_r   <= mp5lf_pkg::mm4(4 * s0_dc_r - s0_dp_r, 4 * s0_dp_r - s0_dc_r,
                                  s0_dc_r, s0_dp_r);
      s1_c60_r  <= s0_c60_r;
      s1_d60_r  <= s0_d60_r;
      s1_ul_r   <= s0_ul_r;
      s1_cb30_r <= s0_cb30_r;
      s1_cd_r   <= s0_cd_r;
    end
  end

  // ---------------- stage 2: deviations and curvature bounds ----------------
  mp5lf_pkg::val_t s2_ql_r, s2_x_r, s2_y_r, s2_md_r, s2_lc_r;
  mp5lf_pkg::val_t s2_c60_r, s2_d60_r, s2_ul_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_ql_r  <= s1_ql_r;
      s2_x_r   <= s1_x_r;
      s2_y_r   <= s1_ql_r - 60 * s1_mp_r;
      s2_md_r  <= 30 * (s1_cd_r - s1_cp_r);
      s2_lc_r  <= s1_c60_r + s1_cb30_r + 80 * s1_cm_r;
      s2_c60_r <= s1_c60_r;
      s2_d60_r <= s1_d60_r;
      s2_ul_r  <= s1_ul_r;
    end
  end

  // ---------------- stage 3: magnitudes, interval ----------------
  mp5lf_pkg::val_t s3_ql_r, s3_lo_r, s3_hi_r;
  mp5lf_pkg::mag_t s3_ax_r, s3_ay_r;
  logic            s3_sgn_ok_r;
  mp5lf_pkg::val_t lo1, lo2, hi1, hi2;

  always_comb begin
    lo1 = mp5lf_pkg::min3(s2_c60_r, s2_d60_r, s2_md_r);
    lo2 = mp5lf_pkg::min3(s2_c60_r, s2_ul_r, s2_lc_r);
    hi1 = mp5lf_pkg::max3(s2_c60_r, s2_d60_r, s2_md_r);
    hi2 = mp5lf_pkg::max3(s2_c60_r, s2_ul_r, s2_lc_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_ql_r     <= s2_ql_r;
      s3_lo_r     <= (lo1 > lo2) ? lo1 : lo2;
      s3_hi_r     <= (hi1 < hi2) ? hi1 : hi2;
      s3_ax_r     <= mp5lf_pkg::MW'(s2_x_r[mp5lf_pkg::VW-1] ? -s2_x_r : s2_x_r);
      s3_ay_r     <= mp5lf_pkg::MW'(s2_y_r[mp5lf_pkg::VW-1] ? -s2_y_r : s2_y_r);
      // product is positive only for two nonzero terms of one sign
      s3_sgn_ok_r <= (s2_x_r != '0) && (s2_y_r != '0) &&
                     (s2_x_r[mp5lf_pkg::VW-1] == s2_y_r[mp5lf_pkg::VW-1]);
    end
  end

  // ---------------- stage 4: partial products, median ----------------
  mp5lf_pkg::val_t s4_ql_r, s4_med_r;
  mp5lf_pkg::pp_t  s4_hh_r, s4_hl_r, s4_lh_r, s4_ll_r;
  logic            s4_sgn_ok_r;
  mp5lf_pkg::half_t ax_h, ax_l, ay_h, ay_l;

  always_comb begin
    ax_h = s3_ax_r[mp5lf_pkg::MW-1:mp5lf_pkg::HW];
    ax_l = s3_ax_r[mp5lf_pkg::HW-1:0];
    ay_h = s3_ay_r[mp5lf_pkg::MW-1:mp5lf_pkg::HW];
    ay_l = s3_ay_r[mp5lf_pkg::HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_ql_r     <= s3_ql_r;
      // median(ql, lo, hi) that also tolerates crossed bounds
      s4_med_r    <= s3_ql_r + mp5lf_pkg::mm2(s3_lo_r - s3_ql_r, s3_hi_r - s3_ql_r);
      s4_hh_r     <= mp5lf_pkg::pp_t'(ax_h) * mp5lf_pkg::pp_t'(ay_h);
      s4_hl_r     <= mp5lf_pkg::pp_t'(ax_h) * mp5lf_pkg::pp_t'(ay_l);
      s4_lh_r     <= mp5lf_pkg::pp_t'(ax_l) * mp5lf_pkg::pp_t'(ay_h);
      s4_ll_r     <= mp5lf_pkg::pp_t'(ax_l) * mp5lf_pkg::pp_t'(ay_l);
      s4_sgn_ok_r <= s3_sgn_ok_r;
    end
  end

  // ---------------- stage 5: product sum ----------------
  mp5lf_pkg::val_t s5_ql_r, s5_med_r;
  mp5lf_pkg::prod_t s5_prod_r;
  logic            s5_sgn_ok_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_ql_r     <= s4_ql_r;
      s5_med_r    <= s4_med_r;
      s5_prod_r   <= (mp5lf_pkg::prod_t'(s4_hh_r) << (2 * mp5lf_pkg::HW))
                   + (mp5lf_pkg::prod_t'(s4_hl_r) << mp5lf_pkg::HW)
                   + (mp5lf_pkg::prod_t'(s4_lh_r) << mp5lf_pkg::HW)
                   + mp5lf_pkg::prod_t'(s4_ll_r);
      s5_sgn_ok_r <= s4_sgn_ok_r;
    end
  end

  // ---------------- stage 6: trigger and select ----------------
  mp5lf_pkg::val_t s6_ql_r;
  logic            s6_lim_r;
  logic            trig_6;

  assign trig_6 = s5_sgn_ok_r && (s5_prod_r > mp5lf_pkg::prod_t'(thr_lim_r));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_ql_r  <= trig_6 ? s5_med_r : s5_ql_r;
      s6_lim_r <= trig_6;
    end
  end

  // ---------------- stages 7..9: divide by 60, saturate ----------------
  mp5lf_pkg::r60_en_t r60_en;

  assign r60_en.ld_a = en[7];
  assign r60_en.ld_b = en[8];
  assign r60_en.ld_c = en[9];

  mp5lf_round60 u_round60 (
    .clk    (clk),
    .en     (r60_en),
    .ql_i   (s6_ql_r),
    .lim_i  (s6_lim_r),
    .face_o (out_tdata),
    .lim_o  (out_tuser)
  );

  assign out_tvalid = v_r[NS-1];

  // ---------------- checks ----------------
  logic in_xfer, out_xfer;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !out_tready) |-> !in_tready)
    else $error("input taken while every stage is occupied and output stalled");

  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |=> ($countones(v_r) == $countones($past(v_r))
                      + int'($past(in_xfer)) - int'($past(out_xfer))))
    else $error("pipeline item count does not match transfers");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
